/* rtl/bgr_pkg.sv */
// ----------------------------------------------------------------------------
// Glyph row renderer package
// Field widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package bgr_pkg;

  localparam int ADDR_W     = 14;
  localparam int BYTE_W     = 8;
  localparam int GLYPH_W    = 7;
  localparam int ROW_W      = 5;
  localparam int COLOR_W    = 16;
  localparam int COL_W      = 5;
  localparam int DIM_W      = 6;
  localparam int BPC_W      = 4;
  localparam int SEL_W      = 3;
  localparam int PROD_W     = 13;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_RESULTS = 32;
  localparam int JOB_DEPTH   = 2;
  localparam int PIX_DEPTH   = 2;

  localparam int MAX_GLYPH_WIDTH_DEF  = 32;
  localparam int MAX_GLYPH_HEIGHT_DEF = 32;
  localparam int GLYPH_COUNT_DEF      = 128;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GLYPH_WIDTH  = 4'd0,
    REG_GLYPH_HEIGHT = 4'd1,
    REG_FG_COLOR     = 4'd2,
    REG_BG_COLOR     = 4'd3
  } reg_idx_e;

  localparam logic [DIM_W-1:0]   GLYPH_WIDTH_RST  = 6'd8;
  localparam logic [DIM_W-1:0]   GLYPH_HEIGHT_RST = 6'd8;
  localparam logic [COLOR_W-1:0] FG_COLOR_RST     = 16'hFFFF;
  localparam logic [COLOR_W-1:0] BG_COLOR_RST     = 16'h0000;

  typedef struct packed {
    logic [DIM_W-1:0]   glyph_width;
    logic [DIM_W-1:0]   glyph_height;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
  } cfg_t;

  typedef struct packed {
    logic               is_load;
    logic [ADDR_W-1:0]  addr;
    logic [BYTE_W-1:0]  value;
    logic [SEL_W-1:0]   bit_sel;
    logic [BPC_W-1:0]   bpc;
    logic [DIM_W-1:0]   width;
  } job_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COL_W-1:0]   column;
    logic               last;
  } pix_t;

endpackage

/* rtl/bgr_in_if.sv */
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one load or render request.
// ----------------------------------------------------------------------------
interface bgr_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [bgr_pkg::ADDR_W-1:0]  byte_address;
  logic [bgr_pkg::BYTE_W-1:0]  byte_value;
  logic [bgr_pkg::GLYPH_W-1:0] glyph_index;
  logic [bgr_pkg::ROW_W-1:0]   row;

  modport source (output valid, opcode, byte_address, byte_value, glyph_index, row,
                  input ready);
  modport sink (input valid, opcode, byte_address, byte_value, glyph_index, row,
                output ready);
endinterface

/* rtl/bgr_out_if.sv */
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one rendered pixel.
// ----------------------------------------------------------------------------
interface bgr_out_if;
  logic                        valid;
  logic                        ready;
  logic [bgr_pkg::COLOR_W-1:0] pixel_color;
  logic [bgr_pkg::COL_W-1:0]   column;
  logic                        last_in_row;

  modport source (output valid, pixel_color, column, last_in_row, input ready);
  modport sink (input valid, pixel_color, column, last_in_row, output ready);
endinterface

/* rtl/bgr_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface bgr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bgr_pkg::CFG_IDX_W-1:0]  index;
  logic [bgr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/bitmap_glyph_row_renderer.sv */
// ----------------------------------------------------------------------------
// Bitmap glyph row renderer
// Column-major font store with load and render-row requests.
// ----------------------------------------------------------------------------
// A load transaction writes one byte of the 16384-byte font store. A render
// transaction for a glyph of w columns yields w pixel transactions at one per
// cycle while the pixel channel accepts them; the font memory has a single
// read port, used once per column. The front end registers each request and
// overlaps with rendering through a two-entry job queue. Rows that produce no
// pixels are dropped in the front end. The font store is not cleared after
// reset, so no startup pass is needed. Configuration is to be written only
// while the block is idle.
// ----------------------------------------------------------------------------
module bitmap_glyph_row_renderer #(
  parameter int MAX_GLYPH_WIDTH  = bgr_pkg::MAX_GLYPH_WIDTH_DEF,
  parameter int MAX_GLYPH_HEIGHT = bgr_pkg::MAX_GLYPH_HEIGHT_DEF,
  parameter int GLYPH_COUNT      = bgr_pkg::GLYPH_COUNT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bgr_cfg_if.sink   cfg_i,
  bgr_in_if.sink    in_i,
  bgr_out_if.source out_o
);

  bgr_pkg::cfg_t cfg_q, cfg_d;
  bgr_pkg::job_t front_job, back_job;
  logic          front_valid, front_ready;
  logic          back_valid, back_ready;

  logic [bgr_pkg::COL_W-1:0] exp_col_q, exp_col_d;
  logic                      out_acc;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        bgr_pkg::REG_GLYPH_WIDTH:  cfg_d.glyph_width  = cfg_i.data[bgr_pkg::DIM_W-1:0];
        bgr_pkg::REG_GLYPH_HEIGHT: cfg_d.glyph_height = cfg_i.data[bgr_pkg::DIM_W-1:0];
        bgr_pkg::REG_FG_COLOR:     cfg_d.fg_color     = cfg_i.data[bgr_pkg::COLOR_W-1:0];
        bgr_pkg::REG_BG_COLOR:     cfg_d.bg_color     = cfg_i.data[bgr_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glyph_width  <= bgr_pkg::GLYPH_WIDTH_RST;
      cfg_q.glyph_height <= bgr_pkg::GLYPH_HEIGHT_RST;
      cfg_q.fg_color     <= bgr_pkg::FG_COLOR_RST;
      cfg_q.bg_color     <= bgr_pkg::BG_COLOR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bgr_front #(
    .MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
    .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT),
    .GLYPH_COUNT      (GLYPH_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (in_i),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready),
    .job_o       (front_job)
  );

  bgr_queue #(
    .T     (bgr_pkg::job_t),
    .DEPTH (bgr_pkg::JOB_DEPTH)
  ) u_job_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_job),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_job),
    .level_o      ()
  );

  bgr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (back_valid),
    .job_ready_o (back_ready),
    .job_i       (back_job),
    .out_o       (out_o)
  );

  // Pixels of a row leave in column order, starting over after the last one.
  assign out_acc   = out_o.valid && out_o.ready;
  assign exp_col_d = out_o.last_in_row ? '0 : out_o.column + bgr_pkg::COL_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_col_q <= '0;
    end else if (out_acc) begin
      exp_col_q <= exp_col_d;
    end
  end

  a_column_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (out_o.column == exp_col_q))
    else $error("pixel column out of order");

  a_last_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.column == bgr_pkg::COL_W'(bgr_pkg::MAX_RESULTS - 1)))
      |-> out_o.last_in_row)
    else $error("row runs past the widest glyph");

endmodule

/* rtl/bgr_queue.sv */
// ----------------------------------------------------------------------------
// Small queue
// Register-based FIFO with a fill level, used between pipeline parts.
// ----------------------------------------------------------------------------
module bgr_queue #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_valid_i,
  output logic                       push_ready_o,
  input  T                           push_data_i,
  output logic                       pop_valid_o,
  input  logic                       pop_ready_i,
  output T                           pop_data_o,
  output logic [$clog2(DEPTH+1)-1:0] level_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  T                entry_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign level_o      = count_q;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/bgr_front.sv */
// ----------------------------------------------------------------------------
// Request front end
// Accepts requests, drops renders that produce no pixels and works out the
// first font address of a render row from a registered glyph-width product.
// ----------------------------------------------------------------------------
module bgr_front #(
  parameter int MAX_GLYPH_WIDTH  = bgr_pkg::MAX_GLYPH_WIDTH_DEF,
  parameter int MAX_GLYPH_HEIGHT = bgr_pkg::MAX_GLYPH_HEIGHT_DEF,
  parameter int GLYPH_COUNT      = bgr_pkg::GLYPH_COUNT_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bgr_pkg::cfg_t  cfg_i,
  bgr_in_if.sink         in_i,
  output logic           job_valid_o,
  input  logic           job_ready_i,
  output bgr_pkg::job_t  job_o
);

  localparam int WLim = (MAX_GLYPH_WIDTH < bgr_pkg::MAX_RESULTS) ?
                        MAX_GLYPH_WIDTH : bgr_pkg::MAX_RESULTS;
  localparam int HLim = MAX_GLYPH_HEIGHT;

  logic [bgr_pkg::DIM_W-1:0]  w_sat, h_sat;
  logic [bgr_pkg::BPC_W-1:0]  bpc;
  logic [bgr_pkg::PROD_W-1:0] prod;
  logic                       drop;
  logic                       go;
  logic                       in_acc;
  logic [bgr_pkg::ADDR_W-1:0] start;

  logic                        s1_valid_q;
  logic                        s1_op_q;
  logic                        s1_drop_q;
  logic [bgr_pkg::ADDR_W-1:0]  s1_addr_q;
  logic [bgr_pkg::BYTE_W-1:0]  s1_value_q;
  logic [bgr_pkg::PROD_W-1:0]  s1_prod_q;
  logic [bgr_pkg::BPC_W-1:0]   s1_bpc_q;
  logic [bgr_pkg::DIM_W-1:0]   s1_width_q;
  logic [bgr_pkg::ROW_W-1:0]   s1_row_q;

  always_comb begin
    w_sat = (cfg_i.glyph_width > bgr_pkg::DIM_W'(WLim)) ?
            bgr_pkg::DIM_W'(WLim) : cfg_i.glyph_width;
    h_sat = ({1'b0, cfg_i.glyph_height} > (bgr_pkg::DIM_W+1)'(HLim)) ?
            bgr_pkg::DIM_W'(HLim) : cfg_i.glyph_height;
    bpc   = bgr_pkg::BPC_W'(({1'b0, h_sat} + 7'd7) >> 3);
    prod  = bgr_pkg::PROD_W'(in_i.glyph_index) * bgr_pkg::PROD_W'(w_sat);
    drop  = (in_i.opcode == bgr_pkg::OP_RENDER) &&
            ((w_sat == '0) || (h_sat == '0) || ({1'b0, in_i.row} >= h_sat) ||
             (32'(in_i.glyph_index) >= GLYPH_COUNT));
  end

  assign go          = s1_valid_q && (s1_drop_q || job_ready_i);
  assign in_i.ready  = !s1_valid_q || go;
  assign in_acc      = in_i.valid && in_i.ready;
  assign job_valid_o = s1_valid_q && !s1_drop_q;

  assign start = bgr_pkg::ADDR_W'(17'(s1_prod_q) * 17'(s1_bpc_q)) +
                 bgr_pkg::ADDR_W'(s1_row_q[bgr_pkg::ROW_W-1:bgr_pkg::SEL_W]);

  always_comb begin
    job_o.is_load = (s1_op_q == bgr_pkg::OP_LOAD);
    job_o.addr    = job_o.is_load ? s1_addr_q : start;
    job_o.value   = s1_value_q;
    job_o.bit_sel = s1_row_q[bgr_pkg::SEL_W-1:0];
    job_o.bpc     = s1_bpc_q;
    job_o.width   = s1_width_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q    <= in_i.opcode;
      s1_drop_q  <= drop;
      s1_addr_q  <= in_i.byte_address;
      s1_value_q <= in_i.byte_value;
      s1_prod_q  <= prod;
      s1_bpc_q   <= bpc;
      s1_width_q <= w_sat;
      s1_row_q   <= in_i.row;
    end
  end

endmodule

/* rtl/bgr_back.sv */
// ----------------------------------------------------------------------------
// Render back end
// Holds the font memory, performs loads and walks the columns of a render
// row, one memory read per column, into a small pixel queue.
// ----------------------------------------------------------------------------
module bgr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bgr_pkg::cfg_t  cfg_i,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  bgr_pkg::job_t  job_i,
  bgr_out_if.source      out_o
);

  localparam int Depth = 1 << bgr_pkg::ADDR_W;
  localparam int LW    = $clog2(bgr_pkg::PIX_DEPTH+1);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_RENDER = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [bgr_pkg::BYTE_W-1:0] mem [Depth];
  logic [bgr_pkg::BYTE_W-1:0] mem_rd_q;
  logic                       mem_we, mem_re;

  logic [bgr_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic [bgr_pkg::BPC_W-1:0]  bpc_q, bpc_d;
  logic [bgr_pkg::SEL_W-1:0]  sel_q, sel_d;
  logic [bgr_pkg::DIM_W-1:0]  width_q, width_d;
  logic [bgr_pkg::COL_W-1:0]  col_q, col_d;
  logic                       col_last;

  logic                       rd_valid_q, rd_valid_d;
  logic [bgr_pkg::COL_W-1:0]  rd_col_q;
  logic                       rd_last_q;
  logic [bgr_pkg::SEL_W-1:0]  rd_sel_q;

  logic [LW-1:0]              pix_level;
  logic                       out_pop;
  logic                       issue_ok;
  bgr_pkg::pix_t              pix_in, pix_out;

  assign out_pop  = out_o.valid && out_o.ready;
  assign issue_ok = (int'(pix_level) + int'(rd_valid_q) - int'(out_pop)) <
                    bgr_pkg::PIX_DEPTH;
  assign col_last = (({1'b0, col_q} + bgr_pkg::DIM_W'(1)) == width_q);

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    bpc_d       = bpc_q;
    sel_d       = sel_q;
    width_d     = width_q;
    col_d       = col_q;
    rd_valid_d  = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    job_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          if (job_i.is_load) begin
            mem_we = 1'b1;
          end else begin
            addr_d  = job_i.addr;
            bpc_d   = job_i.bpc;
            sel_d   = job_i.bit_sel;
            width_d = job_i.width;
            col_d   = '0;
            state_d = ST_RENDER;
          end
        end
      end
      ST_RENDER: begin
        if (issue_ok) begin
          mem_re     = 1'b1;
          rd_valid_d = 1'b1;
          addr_d     = addr_q + bgr_pkg::ADDR_W'(bpc_q);
          col_d      = col_q + bgr_pkg::COL_W'(1);
          if (col_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= rd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    bpc_q   <= bpc_d;
    sel_q   <= sel_d;
    width_q <= width_d;
    col_q   <= col_d;
    if (mem_re) begin
      rd_col_q  <= col_q;
      rd_last_q <= col_last;
      rd_sel_q  <= sel_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[job_i.addr] <= job_i.value;
    end
    if (mem_re) begin
      mem_rd_q <= mem[addr_q];
    end
  end

  always_comb begin
    pix_in.color  = mem_rd_q[rd_sel_q] ? cfg_i.fg_color : cfg_i.bg_color;
    pix_in.column = rd_col_q;
    pix_in.last   = rd_last_q;
  end

  bgr_queue #(
    .T     (bgr_pkg::pix_t),
    .DEPTH (bgr_pkg::PIX_DEPTH)
  ) u_pix_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (rd_valid_q),
    .push_ready_o (),
    .push_data_i  (pix_in),
    .pop_valid_o  (out_o.valid),
    .pop_ready_i  (out_o.ready),
    .pop_data_o   (pix_out),
    .level_o      (pix_level)
  );

  assign out_o.pixel_color = pix_out.color;
  assign out_o.column      = pix_out.column;
  assign out_o.last_in_row = pix_out.last;

endmodule
